@@ rtl/stm_pkg.sv @@
package stm_pkg;

    localparam int TRACKS     = 4;
    localparam int LANES      = 4;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = PROD_W + $clog2(LANES);
    localparam int MIX_W      = SUM_W + SCALE_W + 1;
    localparam int FRAC_BITS  = 30;
    localparam int CLIP_MAX   = 32767;
    localparam int IN_W       = LANES * SAMPLE_W;
    localparam int OUT_W      = 2 * SAMPLE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MUTE  = 3'd0,
        CFG_GAIN0 = 3'd1,
        CFG_GAIN1 = 3'd2,
        CFG_GAIN2 = 3'd3,
        CFG_GAIN3 = 3'd4,
        CFG_SCALE = 3'd5
    } t_cfg_idx;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [MIX_W-1:0]  t_mix;

endpackage

@@ rtl/stereo_track_mixdown.sv @@
// Throughput: one frame per clock while the master side accepts. Stages: gain
// multiply, track sum, scale multiply, round-toward-zero and clip into the
// output register. A stall on the master side holds every full stage up to the
// first empty one; no word is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores the
// registers: mute_mask 0, all gains 0, mix_scale 16384.
module stereo_track_mixdown
    import stm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sample_track_0, sample_track_1, sample_track_2, sample_track_3
    input  logic [IN_W-1:0]       s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // left_out, right_out
    output logic [OUT_W-1:0]      m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [LANES-1:0]      r_mute;
    logic [2*GAIN_W-1:0]   r_gain [LANES];
    logic [SCALE_W-1:0]    r_scale;

    logic                  r_v1, r_v2, r_v3, r_v4;
    t_prod                 r_pl [LANES];
    t_prod                 r_pr [LANES];
    t_sum                  r_sl, r_sr;
    t_mix                  r_ml, r_mr;
    logic [OUT_W-1:0]      r_out;

    logic                  rdy1, rdy2, rdy3, rdy4;
    t_prod                 n_pl [LANES];
    t_prod                 n_pr [LANES];
    t_sum                  n_sl, n_sr;

    assign rdy4          = !r_v4 || m_axis_tready;
    assign rdy3          = !r_v3 || rdy4;
    assign rdy2          = !r_v2 || rdy3;
    assign rdy1          = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r_out;

    function automatic logic [SAMPLE_W-1:0] finish(input t_mix v);
        t_mix                          b;
        logic signed [MIX_W-FRAC_BITS-1:0] q;
        logic [SAMPLE_W-1:0]           res;
        b = v;
        if (v[MIX_W-1]) begin
            b = v + t_mix'((64'd1 << FRAC_BITS) - 64'd1);
        end
        q = b[MIX_W-1:FRAC_BITS];
        if (q > (MIX_W-FRAC_BITS)'(CLIP_MAX)) begin
            res = SAMPLE_W'(CLIP_MAX);
        end else if (q < -(MIX_W-FRAC_BITS)'(CLIP_MAX)) begin
            res = SAMPLE_W'(-CLIP_MAX);
        end else begin
            res = q[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mute  <= '0;
            for (int i = 0; i < LANES; i++) r_gain[i] <= '0;
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MUTE:  r_mute    <= i_cfg_data[LANES-1:0];
                CFG_GAIN0: r_gain[0] <= i_cfg_data;
                CFG_GAIN1: r_gain[1] <= i_cfg_data;
                CFG_GAIN2: r_gain[2] <= i_cfg_data;
                CFG_GAIN3: r_gain[3] <= i_cfg_data;
                CFG_SCALE: r_scale   <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [SAMPLE_W-1:0] s;
        logic signed [GAIN_W:0]     gl, gr;
        logic signed [PROD_W:0]     pl, pr;
        for (int i = 0; i < LANES; i++) begin
            s  = s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
            gl = {1'b0, r_gain[i][GAIN_W-1:0]};
            gr = {1'b0, r_gain[i][2*GAIN_W-1:GAIN_W]};
            pl = s * gl;
            pr = s * gr;
            if (i < TRACKS && !r_mute[i]) begin
                n_pl[i] = pl[PROD_W-1:0];
                n_pr[i] = pr[PROD_W-1:0];
            end else begin
                n_pl[i] = '0;
                n_pr[i] = '0;
            end
        end
    end

    always_comb begin
        n_sl = '0;
        n_sr = '0;
        for (int i = 0; i < LANES; i++) begin
            n_sl = n_sl + t_sum'(r_pl[i]);
            n_sr = n_sr + t_sum'(r_pr[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            for (int i = 0; i < LANES; i++) begin
                r_pl[i] <= n_pl[i];
                r_pr[i] <= n_pr[i];
            end
        end
        if (rdy2 && r_v1) begin
            r_sl <= n_sl;
            r_sr <= n_sr;
        end
        if (rdy3 && r_v2) begin
            r_ml <= t_mix'(r_sl) * t_mix'({1'b0, r_scale});
            r_mr <= t_mix'(r_sr) * t_mix'({1'b0, r_scale});
        end
        if (rdy4 && r_v3) begin
            r_out <= {finish(r_mr), finish(r_ml)};
        end
    end

endmodule

@@ rtl/stm_checker.sv @@
module stm_checker
    import stm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_W-1:0]      m_axis_tdata
);

    // held word must not change under stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // symmetric clip: most negative code never appears
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] != 16'h8000) &&
                          (m_axis_tdata[31:16] != 16'h8000))
        else $error("clip let -32768 through");

    // empty output stage means the whole pipe can take a frame
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output empty");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind stereo_track_mixdown stm_checker u_stm_checker (.*);

@@ sim/stereo_track_mixdown_test.sv @@
module stereo_track_mixdown_test;
    import stm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 116;
    localparam int HOLD_CYCLES = 64;

    // register copy, predicted stereo words and error tally
    class mixdown_ledger;
        logic [3:0]         mute;
        logic [31:0]        gain [LANES];
        logic [SCALE_W-1:0] scale;
        logic [OUT_W-1:0]   due_words [$];
        int                 errors;
        int                 frames;
        int                 clips;

        function new();
            mute = '0;
            foreach (gain[i]) gain[i] = '0;
            scale = SCALE_RESET;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MUTE: mute = val[3:0];
                CFG_GAIN0, CFG_GAIN1, CFG_GAIN2, CFG_GAIN3:
                    gain[int'(idx) - int'(CFG_GAIN0)] = val;
                CFG_SCALE: scale = val[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // drop 30 fraction bits toward zero, then saturate symmetrically
        function logic [SAMPLE_W-1:0] scale_and_clip(longint acc);
            longint y;
            y = (acc * longint'(scale)) / (longint'(1) <<< FRAC_BITS);
            if (y > CLIP_MAX) begin
                y = CLIP_MAX;
                clips++;
            end else if (y < -CLIP_MAX) begin
                y = -CLIP_MAX;
                clips++;
            end
            return y[SAMPLE_W-1:0];
        endfunction

        function void note_frame(logic [IN_W-1:0] data);
            longint left_acc;
            longint right_acc;
            longint s;
            left_acc = 0;
            right_acc = 0;
            for (int i = 0; i < TRACKS && i < LANES; i++) begin
                if (!mute[i]) begin
                    s = longint'($signed(data[i*SAMPLE_W +: SAMPLE_W]));
                    left_acc  += s * longint'(gain[i][15:0]);
                    right_acc += s * longint'(gain[i][31:16]);
                end
            end
            due_words.push_back({scale_and_clip(right_acc), scale_and_clip(left_acc)});
            frames++;
        endfunction

        function void check_word(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (due_words.size() == 0) begin
                $error("stereo word %h with no frame outstanding", got);
                errors++;
                return;
            end
            want = due_words.pop_front();
            if (got[SAMPLE_W-1:0] !== want[SAMPLE_W-1:0]) begin
                $error("left_out: expected %0d, got %0d",
                       $signed(want[SAMPLE_W-1:0]), $signed(got[SAMPLE_W-1:0]));
                errors++;
            end
            if (got[OUT_W-1:SAMPLE_W] !== want[OUT_W-1:SAMPLE_W]) begin
                $error("right_out: expected %0d, got %0d",
                       $signed(want[OUT_W-1:SAMPLE_W]), $signed(got[OUT_W-1:SAMPLE_W]));
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;   // sample_track_0 .. sample_track_3
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;   // left_out, right_out
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mixdown_ledger ledger;
    bit            idle_on = 1'b1;
    bit            hold_req = 1'b0;
    int            settings = 0;

    stereo_track_mixdown u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [IN_W-1:0] frame_of(int t0, int t1, int t2, int t3);
        logic [IN_W-1:0] f;
        f[0*SAMPLE_W +: SAMPLE_W] = t0[SAMPLE_W-1:0];
        f[1*SAMPLE_W +: SAMPLE_W] = t1[SAMPLE_W-1:0];
        f[2*SAMPLE_W +: SAMPLE_W] = t2[SAMPLE_W-1:0];
        f[3*SAMPLE_W +: SAMPLE_W] = t3[SAMPLE_W-1:0];
        return f;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // loud frames push every track towards one rail so the clip is exercised
    function automatic logic [IN_W-1:0] pick_frame();
        logic [IN_W-1:0] f;
        bit              loud;
        bit              neg;
        loud = ($urandom_range(0, 3) == 0);
        neg  = 1'($urandom_range(0, 1));
        for (int i = 0; i < LANES; i++) begin
            if (loud)
                f[i*SAMPLE_W +: SAMPLE_W] = neg ? 16'($urandom_range(32768, 36000))
                                                : 16'($urandom_range(29000, 32767));
            else if ($urandom_range(0, 7) == 0)
                f[i*SAMPLE_W +: SAMPLE_W] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            else
                f[i*SAMPLE_W +: SAMPLE_W] = 16'($urandom);
        end
        return f;
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.write_reg(idx, val);
    endtask

    task automatic program_mixer(input logic [3:0] mute, input logic [31:0] g0,
                                 input logic [31:0] g1, input logic [31:0] g2,
                                 input logic [31:0] g3, input logic [SCALE_W-1:0] scale);
        put_reg(CFG_MUTE, {28'd0, mute});
        put_reg(CFG_GAIN0, g0);
        put_reg(CFG_GAIN1, g1);
        put_reg(CFG_GAIN2, g2);
        put_reg(CFG_GAIN3, g3);
        put_reg(CFG_SCALE, {16'd0, scale});
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic send_frame(input logic [IN_W-1:0] data);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_frame(data);
    endtask

    // stop offering and let the pipeline empty before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ledger.due_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // output side: checks words and stalls in bursts, plus one long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                ledger.check_word(m_axis_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[stereo_track_mixdown] ERROR");
        $finish;
    end

    initial begin
        logic [15:0]        gl [LANES];
        logic [15:0]        gr [LANES];
        logic [3:0]         mute;
        logic [SCALE_W-1:0] scale;
        logic [SCALE_W-1:0] scale_pick [PHASES];

        scale_pick = '{16'd16384, 16'd65535, 16'd0, 16'd32768,
                       16'd23170, 16'd18919, 16'd1, 16'd16384};
        ledger = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_MUTE;
        i_cfg_data    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains are zero: full-scale input must come out silent
        send_frame(frame_of(32767, -32768, 32767, -32768));
        send_frame(frame_of(-1, 1, -32768, 32767));
        drain();

        // writes to unused indexes must leave the mix untouched
        put_reg(CFG_UNUSED_A, 32'hFFFF_FFFF);
        put_reg(CFG_UNUSED_B, 32'h8000_8000);
        i_cfg_valid <= 1'b0;
        send_frame(frame_of(32767, 32767, 32767, 32767));
        drain();

        // maximum gain and scale: both rails clip, negative side at -32767
        program_mixer(4'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      16'hFFFF);
        send_frame(frame_of(32767, 32767, 32767, 32767));
        send_frame(frame_of(-32768, -32768, -32768, -32768));
        send_frame(frame_of(32767, -32768, 32767, -32768));
        send_frame(frame_of(0, 0, 0, 0));
        send_frame(frame_of(-1, -1, -1, -1));
        drain();

        // unity left, tiny right: single-track impulses and truncation toward zero
        program_mixer(4'h0, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000,
                      16'd32768);
        send_frame(frame_of(32767, 0, 0, 0));
        send_frame(frame_of(0, -32768, 0, 0));
        send_frame(frame_of(0, 0, -3, 0));
        send_frame(frame_of(0, 0, 0, 12345));
        drain();

        program_mixer(4'h0, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000,
                      16'd23170);
        send_frame(frame_of(-7, -7, -7, -7));
        send_frame(frame_of(7, 7, 7, 7));
        drain();

        // everything muted
        program_mixer(4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      16'hFFFF);
        send_frame(frame_of(32767, -32768, 32767, -32768));
        send_frame(frame_of(-32768, -32768, -32768, -32768));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1)
                idle_on = 1'b0;
            foreach (gl[i]) begin
                gl[i] = pick_gain();
                gr[i] = pick_gain();
            end
            mute  = (p % 3 == 0) ? 4'h0 : 4'($urandom_range(0, 15));
            scale = (p == 6) ? SCALE_W'($urandom) : scale_pick[p];
            program_mixer(mute, {gr[0], gl[0]}, {gr[1], gl[1]}, {gr[2], gl[2]},
                          {gr[3], gl[3]}, scale);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 30)
                    hold_req = 1'b1;
                send_frame(pick_frame());
            end
            drain();
        end

        if (ledger.due_words.size() != 0) begin
            $error("%0d stereo words never arrived", ledger.due_words.size());
            ledger.errors++;
        end
        $display("Mixed %0d frames under %0d register settings, unused indexes included;",
                 ledger.frames, settings);
        $display("%0d channel samples hit the clip, one long output stall applied.",
                 ledger.clips);
        if (ledger.errors == 0)
            $display("[stereo_track_mixdown] OK");
        else
            $display("[stereo_track_mixdown] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/stm_pkg.sv
rtl/stereo_track_mixdown.sv
rtl/stm_checker.sv
sim/stereo_track_mixdown_test.sv
